@@ hdl/ptrj_pkg.sv @@
`default_nettype none

package ptrj_pkg;

    // Largest duration that fits the joined train.
    localparam logic [15:0] DUR_MAX = 16'hFFFF;

    // Default limit on durations placed in one run.
    localparam int MAX_PULSES_DEFAULT = 512;

    // One input item causes at most this many result items.
    localparam int RES_MAX = 3;

    // Depth of the result queue; must leave room for RES_MAX pushes.
    localparam int QUEUE_DEPTH = 8;

    // One result item of the joined train.
    typedef struct packed {
        logic [15:0] dur;
        logic        level;
        logic        last;
        logic        failed;
    } ptrj_res_t;

endpackage

`default_nettype wire

@@ hdl/pulse_train_run_joiner_top.sv @@
// Pulse train run joiner.
// Input channel (in_valid/in_ready) carries one duration of a recorded frame
// per item, with frame_start, start_level, gap and end_of_run beside it.
// Output channel (out_valid/out_ready) carries the joined train, one duration
// per item, with its level, a last flag and a failed flag on the final item.
// An accepted item lands in an input register; when the queue has room for
// three results, the joining logic updates the held duration and pushes zero
// to three result items into an 8-entry result queue. The results of an item
// are offered from the head of that queue, behind any older results.
// The input register is drained in every cycle in which the queue has at
// least three free entries, so one item per cycle is accepted while the
// consumer takes one result per cycle; an item that causes two or three
// results costs extra cycles only through the one-result-per-cycle drain.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost. Reset empties the queue and the input register and closes any run.
`default_nettype none

module pulse_train_run_joiner_top #(
    parameter int MAX_PULSES = ptrj_pkg::MAX_PULSES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] duration,
    input  wire logic        frame_start,
    input  wire logic        start_level,
    input  wire logic [31:0] gap,
    input  wire logic        end_of_run,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_duration,
    output logic             level,
    output logic             last,
    output logic             failed
);

    localparam int CNT_W = $clog2(MAX_PULSES + 1);
    localparam int QPTR_W = $clog2(ptrj_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(ptrj_pkg::QUEUE_DEPTH + 1);
    localparam int NRES_W = $clog2(ptrj_pkg::RES_MAX + 1);

    // Input register.
    logic        in_vld_reg;
    logic [15:0] dur_reg;
    logic        fs_reg;
    logic        fl_reg;
    logic [31:0] gap_reg;
    logic        eor_reg;

    // Join state.
    logic [15:0]      held_dur_reg, held_dur_next;
    logic             held_lvl_reg, held_lvl_next;
    logic             held_vld_reg, held_vld_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             failed_reg, failed_next;
    logic             in_run_reg, in_run_next;
    logic             await_reg, await_next;

    // Result queue.
    ptrj_pkg::ptrj_res_t queue_mem [ptrj_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   q_cnt_reg;

    // Results of the item being processed.
    ptrj_pkg::ptrj_res_t res [ptrj_pkg::RES_MAX];
    logic [NRES_W-1:0]   nres;

    logic        fire;
    logic        pop;
    logic [32:0] silence;
    logic [33:0] merged;
    logic [15:0] pv;
    logic        plvl;

    // Process the held item when the queue can take a full burst of results.
    assign fire = in_vld_reg &&
                  (q_cnt_reg <= QCNT_W'(ptrj_pkg::QUEUE_DEPTH - ptrj_pkg::RES_MAX));
    assign in_ready = !in_vld_reg || fire;
    assign pop = out_valid && out_ready;

    // Input register capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dur_reg <= duration;
            fs_reg  <= frame_start;
            fl_reg  <= start_level;
            gap_reg <= gap;
            eor_reg <= end_of_run;
        end
    end

    // Silence of a new frame, with a low first duration folded in.
    assign silence = {1'b0, gap_reg} + (fl_reg ? 33'd0 : {17'd0, dur_reg});
    assign merged  = {18'd0, held_dur_reg} + {1'b0, silence};

    // Joining logic for one item.
    always_comb
    begin
        held_dur_next = held_dur_reg;
        held_lvl_next = held_lvl_reg;
        held_vld_next = held_vld_reg;
        cnt_next      = cnt_reg;
        failed_next   = failed_reg;
        in_run_next   = in_run_reg;
        await_next    = await_reg;
        nres          = '0;
        pv            = '0;
        plvl          = 1'b0;
        for (int i = 0; i < ptrj_pkg::RES_MAX; i++)
        begin
            res[i] = '0;
        end

        if (!in_run_reg)
        begin
            // The first item of a run opens the first frame.
            held_dur_next = '0;
            held_lvl_next = 1'b0;
            held_vld_next = 1'b0;
            cnt_next      = '0;
            failed_next   = 1'b0;
            await_next    = 1'b0;
            in_run_next   = 1'b1;
            held_dur_next = dur_reg;
            held_lvl_next = fl_reg;
            held_vld_next = 1'b1;
            cnt_next      = CNT_W'(1);
        end
        else if (fs_reg)
        begin
            // A frame that held only its silence fails the run.
            if (await_reg)
            begin
                failed_next = 1'b1;
            end
            await_next = 1'b0;
            if (!failed_next)
            begin
                if (held_vld_reg && !held_lvl_reg)
                begin
                    // Silence extends the trailing low.
                    if (merged > {18'd0, ptrj_pkg::DUR_MAX})
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        held_dur_next = merged[15:0];
                    end
                end
                else
                begin
                    // Silence becomes a low of its own.
                    if (silence > {17'd0, ptrj_pkg::DUR_MAX} ||
                        cnt_next >= CNT_W'(MAX_PULSES))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (held_vld_next)
                        begin
                            res[nres] = '{dur: held_dur_next, level: held_lvl_next,
                                          last: 1'b0, failed: 1'b0};
                            nres = nres + NRES_W'(1);
                        end
                        held_dur_next = silence[15:0];
                        held_lvl_next = 1'b0;
                        held_vld_next = 1'b1;
                        cnt_next      = cnt_next + CNT_W'(1);
                    end
                end
                if (!fl_reg)
                begin
                    await_next = 1'b1;
                end
                else
                begin
                    pv   = dur_reg;
                    plvl = !held_lvl_next;
                end
            end
        end
        else
        begin
            await_next = 1'b0;
            pv   = dur_reg;
            plvl = !held_lvl_reg;
        end

        // Place the frame body duration, when there is one.
        if (in_run_reg && !(fs_reg && (failed_next || !fl_reg)) && !failed_next)
        begin
            if (cnt_next >= CNT_W'(MAX_PULSES))
            begin
                failed_next = 1'b1;
            end
            else
            begin
                if (held_vld_next)
                begin
                    res[nres] = '{dur: held_dur_next, level: held_lvl_next,
                                  last: 1'b0, failed: 1'b0};
                    nres = nres + NRES_W'(1);
                end
                held_dur_next = pv;
                held_lvl_next = plvl;
                held_vld_next = 1'b1;
                cnt_next      = cnt_next + CNT_W'(1);
            end
        end

        // End of run: final item, then the run closes.
        if (eor_reg)
        begin
            if (await_next)
            begin
                failed_next = 1'b1;
            end
            if (failed_next || !held_vld_next)
            begin
                res[nres] = '{dur: 16'd0, level: 1'b0, last: 1'b1, failed: 1'b1};
            end
            else
            begin
                res[nres] = '{dur: held_dur_next, level: held_lvl_next,
                              last: 1'b1, failed: 1'b0};
            end
            nres = nres + NRES_W'(1);
            held_dur_next = '0;
            held_lvl_next = 1'b0;
            held_vld_next = 1'b0;
            cnt_next      = '0;
            failed_next   = 1'b0;
            in_run_next   = 1'b0;
            await_next    = 1'b0;
        end
    end

    // Join state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_dur_reg <= '0;
            held_lvl_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            failed_reg   <= 1'b0;
            in_run_reg   <= 1'b0;
            await_reg    <= 1'b0;
        end
        else if (fire)
        begin
            held_dur_reg <= held_dur_next;
            held_lvl_reg <= held_lvl_next;
            held_vld_reg <= held_vld_next;
            cnt_reg      <= cnt_next;
            failed_reg   <= failed_next;
            in_run_reg   <= in_run_next;
            await_reg    <= await_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < ptrj_pkg::RES_MAX; i++)
            begin
                if (NRES_W'(i) < nres)
                begin
                    queue_mem[wr_ptr_reg + QPTR_W'(i)] <= res[i];
                end
            end
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(nres);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            q_cnt_reg <= q_cnt_reg + (fire ? QCNT_W'(nres) : QCNT_W'(0))
                         - (pop ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // Output channel.
    assign out_valid    = (q_cnt_reg != '0);
    assign out_duration = queue_mem[rd_ptr_reg].dur;
    assign level        = queue_mem[rd_ptr_reg].level;
    assign last         = queue_mem[rd_ptr_reg].last;
    assign failed       = queue_mem[rd_ptr_reg].failed;

endmodule

`default_nettype wire

@@ verif/tb_pulse_train_run_joiner_top.sv @@
`default_nettype none

module tb_pulse_train_run_joiner_top;

    localparam int PULSE_LIMIT  = ptrj_pkg::MAX_PULSES_DEFAULT;
    localparam int BY_MODEL     = -1;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 215;
    localparam int LONG_RUN_LEN = 40;

    // One input item of a recorded frame.
    typedef struct packed {
        logic [15:0] dur;
        logic        fs;
        logic        fl;
        logic [31:0] gap;
        logic        eor;
    } frame_item_t;

    // One queued item with its idle time and, for some directed rows, a typed result.
    typedef struct {
        frame_item_t         it;
        int                  idle;
        int                  exp_n;
        ptrj_pkg::ptrj_res_t typed;
        bit                  kick;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [15:0] duration;
    logic frame_start;
    logic start_level;
    logic [31:0] gap;
    logic end_of_run;
    logic out_valid;
    logic out_ready;
    logic [15:0] out_duration;
    logic level;
    logic last;
    logic failed;

    stim_t               stim_q[$];
    ptrj_pkg::ptrj_res_t train_exp_q[$];
    int                  err_cnt = 0;
    int                  cycle_cnt = 0;
    int                  burst_left = 0;
    bit                  hold_req = 1'b0;
    bit                  hold_done = 1'b0;

    // Joiner state as the predictor sees it.
    logic [15:0]         jn_held_dur;
    logic                jn_held_lvl;
    logic                jn_held_vld;
    logic                jn_failed;
    logic                jn_in_run;
    logic                jn_awaiting;
    int                  jn_count;
    ptrj_pkg::ptrj_res_t step_res[0:2];
    int                  step_n;

    pulse_train_run_joiner_top #(
        .MAX_PULSES(PULSE_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .duration(duration),
        .frame_start(frame_start),
        .start_level(start_level),
        .gap(gap),
        .end_of_run(end_of_run),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_duration(out_duration),
        .level(level),
        .last(last),
        .failed(failed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic jn_clear();
        jn_held_dur = '0;
        jn_held_lvl = 1'b0;
        jn_held_vld = 1'b0;
        jn_count    = 0;
        jn_failed   = 1'b0;
        jn_in_run   = 1'b0;
        jn_awaiting = 1'b0;
    endtask

    task automatic jn_emit(input logic [15:0] d, input logic l, input logic a, input logic f);
        step_res[step_n] = '{dur: d, level: l, last: a, failed: f};
        step_n++;
    endtask

    // Places a new duration; the one held so far goes out.
    task automatic jn_place(input logic [33:0] v, input logic lvl);
        if (jn_failed)
            return;
        if (v > {18'b0, ptrj_pkg::DUR_MAX} || jn_count >= PULSE_LIMIT)
        begin
            jn_failed = 1'b1;
            return;
        end
        if (jn_held_vld)
            jn_emit(jn_held_dur, jn_held_lvl, 1'b0, 1'b0);
        jn_held_dur = v[15:0];
        jn_held_lvl = lvl;
        jn_held_vld = 1'b1;
        jn_count++;
    endtask

    // Works out the joined train items that one accepted input item causes.
    task automatic join_predict(input frame_item_t it);
        logic [33:0] silence;
        logic [33:0] merged;
        logic        absorbed;
        step_n = 0;
        if (!jn_in_run)
        begin
            jn_clear();
            jn_in_run = 1'b1;
            jn_place({18'b0, it.dur}, it.fl);
        end
        else if (it.fs)
        begin
            if (jn_awaiting)
                jn_failed = 1'b1;
            jn_awaiting = 1'b0;
            if (!jn_failed)
            begin
                silence  = {2'b0, it.gap};
                absorbed = 1'b0;
                if (!it.fl)
                begin
                    silence  = silence + {18'b0, it.dur};
                    absorbed = 1'b1;
                end
                if (jn_held_vld && !jn_held_lvl)
                begin
                    merged = {18'b0, jn_held_dur} + silence;
                    if (merged > {18'b0, ptrj_pkg::DUR_MAX})
                        jn_failed = 1'b1;
                    else
                        jn_held_dur = merged[15:0];
                end
                else
                begin
                    jn_place(silence, 1'b0);
                end
                if (absorbed)
                    jn_awaiting = 1'b1;
                else
                    jn_place({18'b0, it.dur}, ~jn_held_lvl);
            end
        end
        else
        begin
            jn_awaiting = 1'b0;
            jn_place({18'b0, it.dur}, ~jn_held_lvl);
        end

        // Close the run on its final item.
        if (it.eor)
        begin
            if (jn_awaiting)
                jn_failed = 1'b1;
            if (jn_failed || !jn_held_vld)
                jn_emit(16'h0, 1'b0, 1'b1, 1'b1);
            else
                jn_emit(jn_held_dur, jn_held_lvl, 1'b1, 1'b0);
            jn_clear();
        end
    endtask

    // Sender bursts: runs of back-to-back items separated by short gaps.
    function automatic int next_idle();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 20);
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [15:0] rand_dur();
        case ($urandom_range(0, 7))
            0: return 16'h0;
            1, 2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic [31:0] rand_gap();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return $urandom;
            default: return 32'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic push_stim(input frame_item_t it, input int idle, input int exp_n,
                             input ptrj_pkg::ptrj_res_t typed, input bit kick);
        stim_t s;
        s.it    = it;
        s.idle  = idle;
        s.exp_n = exp_n;
        s.typed = typed;
        s.kick  = kick;
        stim_q.push_back(s);
    endtask

    // One row of the directed table.
    task automatic dir_row(input logic [15:0] d, input logic fs, input logic fl,
                           input logic [31:0] g, input logic eor, input int exp_n,
                           input logic [15:0] e_dur, input logic e_lvl,
                           input logic e_last, input logic e_fail);
        push_stim('{dur: d, fs: fs, fl: fl, gap: g, eor: eor}, next_idle(), exp_n,
                  '{dur: e_dur, level: e_lvl, last: e_last, failed: e_fail}, 1'b0);
    endtask

    // A run of well-formed frames with random content and some noise mixed in.
    task automatic gen_run(inout int n_items);
        frame_item_t it;
        int n_frames;
        int len;
        logic fl;
        n_frames = $urandom_range(1, 5);
        for (int f = 0; f < n_frames; f++)
        begin
            len = $urandom_range(1, 6);
            fl  = 1'($urandom_range(0, 1));
            for (int k = 0; k < len; k++)
            begin
                it.dur = rand_dur();
                it.fs  = (k == 0);
                it.fl  = (k == 0) ? fl : 1'($urandom_range(0, 1));
                it.gap = rand_gap();
                it.eor = (f == n_frames - 1) && (k == len - 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    it.fs = 1'($urandom_range(0, 1));
                    it.fl = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 29) == 0)
                    it.eor = 1'b1;
                push_stim(it, next_idle(), BY_MODEL, '0, 1'b0);
                n_items++;
            end
        end
    endtask

    // One long run of back-to-back frames, each placing two durations, sent
    // while the receiver holds off so that the result queue fills up.
    task automatic gen_long_run();
        frame_item_t it;
        for (int k = 0; k < LONG_RUN_LEN; k++)
        begin
            it.dur = 16'($urandom_range(1, 3000));
            it.fs  = 1'b1;
            it.fl  = 1'b1;
            it.gap = 32'($urandom_range(0, 100));
            it.eor = (k == LONG_RUN_LEN - 1);
            push_stim(it, 0, BY_MODEL, '0, k == 0);
        end
    endtask

    // Build the stimulus: directed table first, then random runs.
    initial
    begin
        int n_items;
        n_items = 0;

        // Single-item runs right after reset: widest duration, and frame_start low.
        dir_row(16'hFFFF, 1, 1, 32'h0,        1, 1,        16'hFFFF, 1, 1, 0);
        dir_row(16'h0000, 0, 0, 32'hFFFFFFFF, 1, 1,        16'h0000, 0, 1, 0);
        // A normal join: zero gap, merge into a trailing low, widest inserted silence.
        dir_row(16'd100,  1, 1, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd200,  0, 1, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd300,  0, 0, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd400,  1, 1, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd10,   0, 1, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd20,   1, 0, 32'd1000,     0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd5,    0, 0, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd6,    1, 1, 32'd7,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'hFFFF, 1, 0, 32'h0,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd1,    0, 1, 32'h0,        1, BY_MODEL, 0, 0, 0, 0);
        // Inserted silence too long from the widest gap.
        dir_row(16'd10,   1, 1, 32'h0,        0, 0,        0, 0, 0, 0);
        dir_row(16'd1,    1, 1, 32'hFFFFFFFF, 1, 1,        16'h0, 0, 1, 1);
        // Merged silence too long; the gap of the first item is ignored.
        dir_row(16'd65000, 1, 0, 32'h12345678, 0, 0,       0, 0, 0, 0);
        dir_row(16'd5,    1, 1, 32'd600,      0, 0,        0, 0, 0, 0);
        dir_row(16'd1,    0, 1, 32'h0,        1, 1,        16'h0, 0, 1, 1);
        // Absorbed silence one past the widest duration.
        dir_row(16'd3,    1, 1, 32'h0,        0, 0,        0, 0, 0, 0);
        dir_row(16'd1,    1, 0, 32'h0000FFFF, 1, 1,        16'h0, 0, 1, 1);
        // Frame of silence only, ended by a new frame start.
        dir_row(16'd7,    1, 1, 32'h0,        0, 0,        0, 0, 0, 0);
        dir_row(16'd4,    1, 0, 32'd3,        0, BY_MODEL, 0, 0, 0, 0);
        dir_row(16'd9,    1, 1, 32'd2,        0, 0,        0, 0, 0, 0);
        dir_row(16'd1,    0, 1, 32'h0,        1, 1,        16'h0, 0, 1, 1);
        // Frame of silence only, ended by the end of the run.
        dir_row(16'd7,    1, 1, 32'h0,        0, 0,        0, 0, 0, 0);
        dir_row(16'd4,    1, 0, 32'd3,        1, BY_MODEL, 0, 0, 0, 0);

        while (n_items < RANDOM_ITEMS / 2)
            gen_run(n_items);
        gen_long_run();
        while (n_items < RANDOM_ITEMS)
            gen_run(n_items);
    end

    // Sender: drives items, predicts on acceptance, then waits for the train to drain.
    initial
    begin
        stim_t cur;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        duration    = '0;
        frame_start = 1'b0;
        start_level = 1'b0;
        gap         = '0;
        end_of_run  = 1'b0;
        jn_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (stim_q.size() > 0)
        begin
            cur = stim_q.pop_front();
            if (cur.idle > 0)
            begin
                in_valid <= 1'b0;
                repeat (cur.idle) @(posedge clk);
            end
            if (cur.kick)
                hold_req = 1'b1;
            in_valid    <= 1'b1;
            duration    <= cur.it.dur;
            frame_start <= cur.it.fs;
            start_level <= cur.it.fl;
            gap         <= cur.it.gap;
            end_of_run  <= cur.it.eor;
            @(negedge clk);
            while (in_ready !== 1'b1)
                @(negedge clk);
            @(posedge clk);
            join_predict(cur.it);
            if (cur.exp_n == BY_MODEL)
            begin
                for (int i = 0; i < step_n; i++)
                    train_exp_q.push_back(step_res[i]);
            end
            else
            begin
                for (int i = 0; i < cur.exp_n; i++)
                    train_exp_q.push_back(cur.typed);
            end
        end
        in_valid <= 1'b0;

        while (train_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: stall patterns that change by segment, plus one long hold-off.
    initial
    begin
        int seg_left;
        int mode;
        int phase;
        seg_left  = 0;
        mode      = 0;
        phase     = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 100);
            end
            seg_left--;
            phase++;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (phase % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (a !== e)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endtask

    // Monitor: a result item moves at the next rising edge, so sample it at the falling one.
    always @(negedge clk)
    begin
        ptrj_pkg::ptrj_res_t exp_res;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (train_exp_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected item, expected none, actual %0h %0b %0b %0b",
                         $time, out_duration, level, last, failed);
            end
            else
            begin
                exp_res = train_exp_q.pop_front();
                cmp_field("out_duration", exp_res.dur, out_duration);
                cmp_field("level", {15'b0, exp_res.level}, {15'b0, level});
                cmp_field("last", {15'b0, exp_res.last}, {15'b0, last});
                cmp_field("failed", {15'b0, exp_res.failed}, {15'b0, failed});
            end
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/ptrj_pkg.sv
hdl/pulse_train_run_joiner_top.sv
verif/tb_pulse_train_run_joiner_top.sv
